@@ rtl/bvm_pkg.sv @@
// Battery voltage monitor: shared types, widths, register indexes and reset values.
// No dependencies; used by bvm_div and battery_voltage_monitor.
package bvm_pkg;

    localparam int MV_WIDTH = 13;              // stored voltage width, 12..16
    localparam int ADC_W    = 12;
    localparam int REG_W    = 13;              // millivolt register width
    localparam int TMR_W    = 20;
    localparam int CW       = 16;              // compare width, covers MV_WIDTH range
    localparam int NUM_W    = 20;              // (v - critical) * 100 fits below 2^20
    localparam int PCT_W    = 7;
    localparam int QSTEPS   = 7;               // quotient is below 128
    localparam int QCNT_W   = $clog2(QSTEPS);
    localparam int CFG_AW   = 3;
    localparam int IN_DW    = 16;
    localparam int OUT_DW   = 32;

    localparam logic [TMR_W-1:0] TIMER_MAX     = '1;
    localparam logic [TMR_W-1:0] RST_POLL      = TMR_W'(60000);
    localparam logic [REG_W-1:0] RST_VALID_MIN = REG_W'(2500);
    localparam logic [REG_W-1:0] RST_VALID_MAX = REG_W'(5000);
    localparam logic [REG_W-1:0] RST_FULL      = REG_W'(4200);
    localparam logic [REG_W-1:0] RST_LOW       = REG_W'(3500);
    localparam logic [REG_W-1:0] RST_CRITICAL  = REG_W'(3300);
    localparam logic [PCT_W-1:0] PCT_FULL      = PCT_W'(100);

    typedef enum logic [CFG_AW-1:0] {
        CFG_POLL_INTERVAL = 3'd0,
        CFG_VALID_MIN     = 3'd1,
        CFG_VALID_MAX     = 3'd2,
        CFG_FULL          = 3'd3,
        CFG_LOW           = 3'd4,
        CFG_CRITICAL      = 3'd5
    } t_cfg_idx;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_UPD,
        ST_EVAL,
        ST_DIV,
        ST_FIN
    } t_state;

    typedef struct packed {
        logic             start;
        logic [NUM_W-1:0] num;
        logic [REG_W-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [PCT_W-1:0] quo;
    } t_div_rsp;

endpackage

@@ rtl/bvm_div.sv @@
// Restoring serial divider for the charge estimate, one quotient bit per cycle.
// Depends on bvm_pkg.
module bvm_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  bvm_pkg::t_div_req i_req,
    output bvm_pkg::t_div_rsp o_rsp
);
    import bvm_pkg::*;

    logic              r_busy;
    logic              r_done;
    logic [QCNT_W-1:0] r_cnt;
    logic [NUM_W-1:0]  r_rem;
    logic [NUM_W-1:0]  r_dsh;
    logic [PCT_W-1:0]  r_quo;
    logic              fits;

    assign fits = (r_rem >= r_dsh);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= QCNT_W'(QSTEPS - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= i_req.num;
            r_dsh <= NUM_W'(i_req.den) << (QSTEPS - 1);
            r_quo <= '0;
        end else if (r_busy) begin
            if (fits) begin
                r_rem <= r_rem - r_dsh;
            end
            r_quo <= {r_quo[PCT_W-2:0], fits};
            r_dsh <= r_dsh >> 1;
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_quo;

endmodule

@@ rtl/battery_voltage_monitor.sv @@
// Battery voltage monitor top level: sequencer, poll timer, thresholds, result register.
// Depends on bvm_pkg and bvm_div.
//
// Each input transfer is a millisecond tick or an init request carrying the converter
// reading. The block takes one transfer at a time and returns one result per transfer.
// The sequencer steps through the UPD, EVAL and FIN states after the transfer is taken.
// When a valid reading falls strictly between the critical and full voltages it also
// passes through DIV, where the serial divider runs its 7 quotient steps.
// The input is ready again in the cycle the result appears. A new transfer is taken
// while a previous result still waits in the output register, and a second waiting
// result holds off the input. Configuration writes take effect at once and belong in
// idle periods.
module battery_voltage_monitor (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // configuration
    input  logic                         i_cfg_we,
    input  logic [bvm_pkg::CFG_AW-1:0]   i_cfg_addr,
    input  logic [bvm_pkg::TMR_W-1:0]    i_cfg_wdata,
    // input stream
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    input  logic [bvm_pkg::IN_DW-1:0]    s_axis_tdata,  // [11:0] adc_mv
    input  logic                         s_axis_tuser,  // [0] kind
    // result stream
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    // [12:0] vbat_mv, [13] sampled, [14] reading_valid, [21:15] charge_percent,
    // [22] is_low, [23] is_critical, [24] low_alert
    output logic [bvm_pkg::OUT_DW-1:0]   m_axis_tdata
);
    import bvm_pkg::*;

    // configuration registers
    logic [TMR_W-1:0] r_poll;
    logic [REG_W-1:0] r_vmin, r_vmax, r_full, r_low, r_crit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_poll <= RST_POLL;
            r_vmin <= RST_VALID_MIN;
            r_vmax <= RST_VALID_MAX;
            r_full <= RST_FULL;
            r_low  <= RST_LOW;
            r_crit <= RST_CRITICAL;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_POLL_INTERVAL: r_poll <= i_cfg_wdata;
                CFG_VALID_MIN:     r_vmin <= i_cfg_wdata[REG_W-1:0];
                CFG_VALID_MAX:     r_vmax <= i_cfg_wdata[REG_W-1:0];
                CFG_FULL:          r_full <= i_cfg_wdata[REG_W-1:0];
                CFG_LOW:           r_low  <= i_cfg_wdata[REG_W-1:0];
                CFG_CRITICAL:      r_crit <= i_cfg_wdata[REG_W-1:0];
                default: ;
            endcase
        end
    end

    // sequencer and state
    t_state              r_state, n_state;
    logic                r_kind, n_kind;
    logic [ADC_W-1:0]    r_adc, n_adc;
    logic [MV_WIDTH-1:0] r_stored, n_stored;
    logic [TMR_W-1:0]    r_elapsed, n_elapsed;
    logic                r_latch, n_latch;
    logic                r_sampled, n_sampled;
    logic                r_alert, n_alert;
    logic                r_valid, n_valid;
    logic                r_is_low, n_is_low;
    logic                r_is_crit, n_is_crit;
    logic [PCT_W-1:0]    r_pct, n_pct;
    logic                r_oval, n_oval;
    logic [OUT_DW-1:0]   r_odata, n_odata;

    t_div_req            div_req;
    t_div_rsp            div_rsp;

    logic [MV_WIDTH-1:0] doubled;
    logic [CW-1:0]       dbl_c, cur_c;
    logic [TMR_W-1:0]    ticked;
    logic                dbl_low;
    logic [CW-1:0]       diff;

    bvm_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (div_req),
        .o_rsp  (div_rsp)
    );

    always_comb begin
        n_state   = r_state;
        n_kind    = r_kind;
        n_adc     = r_adc;
        n_stored  = r_stored;
        n_elapsed = r_elapsed;
        n_latch   = r_latch;
        n_sampled = r_sampled;
        n_alert   = r_alert;
        n_valid   = r_valid;
        n_is_low  = r_is_low;
        n_is_crit = r_is_crit;
        n_pct     = r_pct;
        n_oval    = r_oval && !m_axis_tready;
        n_odata   = r_odata;

        doubled = MV_WIDTH'({r_adc, 1'b0});
        dbl_c   = CW'(doubled);
        cur_c   = CW'(r_stored);
        ticked  = (r_elapsed != TIMER_MAX) ? r_elapsed + 1'b1 : r_elapsed;
        dbl_low = (dbl_c >= CW'(r_vmin)) && (dbl_c <= CW'(r_vmax)) && (dbl_c <= CW'(r_low));
        diff    = cur_c - CW'(r_crit);

        div_req.start = 1'b0;
        div_req.num   = NUM_W'(diff) * NUM_W'(PCT_FULL);
        div_req.den   = r_full - r_crit;

        s_axis_tready = (r_state == ST_IDLE);

        case (r_state)
            ST_IDLE: begin
                if (s_axis_tvalid) begin
                    n_kind  = s_axis_tuser;
                    n_adc   = s_axis_tdata[ADC_W-1:0];
                    n_state = ST_UPD;
                end
            end
            ST_UPD: begin
                n_sampled = 1'b0;
                n_alert   = 1'b0;
                if (r_kind) begin
                    n_stored  = doubled;
                    n_elapsed = '0;
                    n_latch   = 1'b0;
                    n_sampled = 1'b1;
                end else if (ticked >= r_poll) begin
                    n_stored  = doubled;
                    n_elapsed = '0;
                    n_sampled = 1'b1;
                    if (dbl_low && !r_latch) begin
                        n_latch = 1'b1;
                        n_alert = 1'b1;
                    end else if (!dbl_low) begin
                        n_latch = 1'b0;
                    end
                end else begin
                    n_elapsed = ticked;
                end
                n_state = ST_EVAL;
            end
            ST_EVAL: begin
                n_valid   = (cur_c >= CW'(r_vmin)) && (cur_c <= CW'(r_vmax));
                n_is_low  = n_valid && (cur_c <= CW'(r_low));
                n_is_crit = n_valid && (cur_c <= CW'(r_crit));
                n_state   = ST_FIN;
                if (!n_valid || cur_c <= CW'(r_crit)) begin
                    n_pct = '0;
                end else if (cur_c >= CW'(r_full)) begin
                    n_pct = PCT_FULL;
                end else begin
                    div_req.start = 1'b1;
                    n_state       = ST_DIV;
                end
            end
            ST_DIV: begin
                if (div_rsp.done) begin
                    n_pct   = div_rsp.quo;
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                if (!r_oval || m_axis_tready) begin
                    n_oval  = 1'b1;
                    n_odata = OUT_DW'({r_alert, r_is_crit, r_is_low, r_pct, r_valid,
                                       r_sampled, REG_W'(r_stored)});
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_stored  <= '0;
            r_elapsed <= '0;
            r_latch   <= 1'b0;
            r_oval    <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_stored  <= n_stored;
            r_elapsed <= n_elapsed;
            r_latch   <= n_latch;
            r_oval    <= n_oval;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind    <= n_kind;
        r_adc     <= n_adc;
        r_sampled <= n_sampled;
        r_alert   <= n_alert;
        r_valid   <= n_valid;
        r_is_low  <= n_is_low;
        r_is_crit <= n_is_crit;
        r_pct     <= n_pct;
        r_odata   <= n_odata;
    end

    assign m_axis_tvalid = r_oval;
    assign m_axis_tdata  = r_odata;

endmodule

@@ tb/tb.sv @@
// Self-checking testbench for battery_voltage_monitor: directed and random tick/init
// streams under several idling patterns, checked against a built-in predictor.
// Depends on bvm_pkg and the battery_voltage_monitor RTL.
module tb;
    import bvm_pkg::*;

    typedef struct packed {
        logic             low_alert;
        logic             is_critical;
        logic             is_low;
        logic [PCT_W-1:0] charge_percent;
        logic             reading_valid;
        logic             sampled;
        logic [12:0]      vbat_mv;
    } t_reading;

    logic                i_clk         = 1'b0;
    logic                i_rst_n       = 1'b0;
    logic                i_cfg_we      = 1'b0;
    logic [CFG_AW-1:0]   i_cfg_addr    = '0;
    logic [TMR_W-1:0]    i_cfg_wdata   = '0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [IN_DW-1:0]    s_axis_tdata  = '0;   // [11:0] adc_mv
    logic                s_axis_tuser  = 1'b0; // [0] kind
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    // [12:0] vbat_mv, [13] sampled, [14] reading_valid, [21:15] charge_percent,
    // [22] is_low, [23] is_critical, [24] low_alert
    logic [OUT_DW-1:0]   m_axis_tdata;

    battery_voltage_monitor dut (.*);

    // predictor state and register copies
    logic [TMR_W-1:0]    cfg_poll      = RST_POLL;
    logic [REG_W-1:0]    cfg_valid_min = RST_VALID_MIN;
    logic [REG_W-1:0]    cfg_valid_max = RST_VALID_MAX;
    logic [REG_W-1:0]    cfg_full      = RST_FULL;
    logic [REG_W-1:0]    cfg_low       = RST_LOW;
    logic [REG_W-1:0]    cfg_critical  = RST_CRITICAL;
    logic [MV_WIDTH-1:0] stored_mv     = '0;
    logic [TMR_W-1:0]    elapsed_ms    = '0;
    logic                alert_latched = 1'b0;

    t_reading pending_readings[$];

    int send_idle_pct   = 0;
    int rx_stall_pct    = 0;
    int rx_hold_len     = 0;
    int mismatches      = 0;
    int transfers_in    = 0;
    int readings_out    = 0;
    int samples_seen    = 0;
    int alerts_seen     = 0;
    int settings_count  = 0;

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    initial begin
        #5_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    function automatic bit in_window(int unsigned v);
        return v >= cfg_valid_min && v <= cfg_valid_max;
    endfunction

    function automatic int unsigned charge_of(int unsigned v);
        if (v <= cfg_critical)
            return 0;
        if (v >= cfg_full)
            return 100;
        return ((v - cfg_critical) * 100) / (cfg_full - cfg_critical);
    endfunction

    function automatic t_reading battery_predict(logic kind, logic [ADC_W-1:0] adc);
        t_reading    r;
        bit          low;
        int unsigned v;
        r = '0;
        if (kind) begin
            stored_mv     = MV_WIDTH'(32'(adc) * 2);
            elapsed_ms    = '0;
            alert_latched = 1'b0;
            r.sampled     = 1'b1;
        end else begin
            if (elapsed_ms != TIMER_MAX)
                elapsed_ms = elapsed_ms + 1'b1;
            if (elapsed_ms >= cfg_poll) begin
                elapsed_ms = '0;
                stored_mv  = MV_WIDTH'(32'(adc) * 2);
                r.sampled  = 1'b1;
                low = in_window(stored_mv) && stored_mv <= cfg_low;
                if (low && !alert_latched) begin
                    alert_latched = 1'b1;
                    r.low_alert   = 1'b1;
                end else if (!low) begin
                    alert_latched = 1'b0;
                end
            end
        end
        v = stored_mv;
        r.vbat_mv       = 13'(v);
        r.reading_valid = in_window(v);
        r.charge_percent = r.reading_valid ? PCT_W'(charge_of(v)) : '0;
        r.is_low        = r.reading_valid && v <= cfg_low;
        r.is_critical   = r.reading_valid && v <= cfg_critical;
        return r;
    endfunction

    function automatic void check_field(string name, int unsigned exp, int unsigned got);
        if (exp != got) begin
            mismatches++;
            if (mismatches <= 10)
                $display("reading %0d, %s: expected %0d, got %0d",
                         readings_out, name, exp, got);
        end
    endfunction

    always @(posedge i_clk) begin : check_proc
        t_reading got;
        t_reading exp;
        if (i_rst_n) begin
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_addr))
                    CFG_POLL_INTERVAL: cfg_poll      = i_cfg_wdata;
                    CFG_VALID_MIN:     cfg_valid_min = i_cfg_wdata[REG_W-1:0];
                    CFG_VALID_MAX:     cfg_valid_max = i_cfg_wdata[REG_W-1:0];
                    CFG_FULL:          cfg_full      = i_cfg_wdata[REG_W-1:0];
                    CFG_LOW:           cfg_low       = i_cfg_wdata[REG_W-1:0];
                    CFG_CRITICAL:      cfg_critical  = i_cfg_wdata[REG_W-1:0];
                    default: ;
                endcase
            end
            if (m_axis_tvalid && m_axis_tready) begin
                got = m_axis_tdata[24:0];
                if (pending_readings.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("reading %0d arrived with no transfer outstanding",
                                 readings_out);
                end else begin
                    exp = pending_readings.pop_front();
                    check_field("vbat_mv", exp.vbat_mv, got.vbat_mv);
                    check_field("sampled", exp.sampled, got.sampled);
                    check_field("reading_valid", exp.reading_valid, got.reading_valid);
                    check_field("charge_percent", exp.charge_percent, got.charge_percent);
                    check_field("is_low", exp.is_low, got.is_low);
                    check_field("is_critical", exp.is_critical, got.is_critical);
                    check_field("low_alert", exp.low_alert, got.low_alert);
                    check_field("padding", 0, m_axis_tdata[OUT_DW-1:25]);
                    samples_seen += exp.sampled;
                    alerts_seen  += exp.low_alert;
                end
                readings_out++;
            end
            if (s_axis_tvalid && s_axis_tready) begin
                pending_readings.push_back(battery_predict(s_axis_tuser,
                                                           s_axis_tdata[ADC_W-1:0]));
                transfers_in++;
            end
        end
    end

    // receiver: random stalls, or a long hold-off when requested
    always @(negedge i_clk) begin
        if (rx_hold_len > 0) begin
            m_axis_tready <= 1'b0;
            rx_hold_len--;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    task automatic send_item(logic kind, logic [ADC_W-1:0] adc);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= IN_DW'(adc);
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic wait_drain();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (pending_readings.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [TMR_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= val;
    endtask

    task automatic apply_settings(logic [TMR_W-1:0] poll, logic [TMR_W-1:0] vmin,
                                  logic [TMR_W-1:0] vmax, logic [TMR_W-1:0] full,
                                  logic [TMR_W-1:0] low, logic [TMR_W-1:0] crit);
        wait_drain();
        write_reg(CFG_POLL_INTERVAL, poll);
        write_reg(CFG_VALID_MIN, vmin);
        write_reg(CFG_VALID_MAX, vmax);
        write_reg(CFG_FULL, full);
        write_reg(CFG_LOW, low);
        write_reg(CFG_CRITICAL, crit);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        settings_count++;
    endtask

    task automatic set_idling(int send_pct, int stall_pct);
        send_idle_pct = send_pct;
        rx_stall_pct  = stall_pct;
    endtask

    // thresholds in millivolts, junk above bit 12 must be ignored
    function automatic logic [TMR_W-1:0] reg_val(int unsigned v);
        return {7'($urandom), 13'(v)};
    endfunction

    function automatic logic [ADC_W-1:0] pick_adc();
        int v;
        case ($urandom_range(3))
            0: v = $urandom_range(4095);
            1: v = int'(cfg_low / 2) + $urandom_range(80) - 40;
            2: v = int'(cfg_critical / 2) + $urandom_range(80) - 40;
            default: v = int'(cfg_full / 2) + $urandom_range(80) - 40;
        endcase
        if (v < 0)
            v = 0;
        if (v > 4095)
            v = 4095;
        return ADC_W'(v);
    endfunction

    task automatic test_reset_defaults();
        send_item(1'b0, 12'd0);
        send_item(1'b1, 12'd4095);
        send_item(1'b1, 12'd2100);
        send_item(1'b1, 12'd1700);
        send_item(1'b1, 12'd1650);
    endtask

    task automatic test_poll_and_alert();
        apply_settings(2, RST_VALID_MIN, RST_VALID_MAX, RST_FULL, RST_LOW, RST_CRITICAL);
        send_item(1'b1, 12'd1700);
        send_item(1'b0, 12'd1700);
        send_item(1'b0, 12'd1700);  // first low poll: alert
        send_item(1'b0, 12'd1700);
        send_item(1'b0, 12'd1690);  // still low and latched
        send_item(1'b0, 12'd2000);
        send_item(1'b0, 12'd2000);  // rearm
        send_item(1'b0, 12'd1700);
        send_item(1'b0, 12'd1700);  // alert again
    endtask

    task automatic test_interval_changes();
        apply_settings(1000, RST_VALID_MIN, RST_VALID_MAX, RST_FULL, RST_LOW, RST_CRITICAL);
        repeat (3) send_item(1'b0, 12'd1900);
        // interval cut below the time already elapsed
        apply_settings(2, RST_VALID_MIN, RST_VALID_MAX, RST_FULL, RST_LOW, RST_CRITICAL);
        send_item(1'b0, 12'd1900);
        apply_settings(0, RST_VALID_MIN, RST_VALID_MAX, RST_FULL, RST_LOW, RST_CRITICAL);
        send_item(1'b0, 12'd1600);
        send_item(1'b0, 12'd1720);
        send_item(1'b0, 12'd1800);
    endtask

    task automatic test_full_below_critical();
        apply_settings(1, RST_VALID_MIN, RST_VALID_MAX, 3000, RST_LOW, RST_CRITICAL);
        send_item(1'b1, 12'd1700);
        send_item(1'b1, 12'd1650);
        send_item(1'b0, 12'd1651);
    endtask

    task automatic test_register_extremes();
        apply_settings(TIMER_MAX, 0, 8191, 8191, 8191, 0);
        send_item(1'b1, 12'd4095);
        send_item(1'b1, 12'd0);
        send_item(1'b0, 12'd2048);
        apply_settings(1, 8191, 0, 1, 0, 8190);
        send_item(1'b1, 12'd4095);
        send_item(1'b0, 12'd0);
        apply_settings(1, 0, 8191, 1, 8191, 8190);
        send_item(1'b0, 12'd4095);
        send_item(1'b0, 12'd4094);
    endtask

    task automatic random_settings();
        int unsigned crit;
        int unsigned full;
        int unsigned low;
        if ($urandom_range(4) == 0) begin
            apply_settings($urandom_range(6), reg_val($urandom), reg_val($urandom),
                           reg_val($urandom), reg_val($urandom), reg_val($urandom));
        end else begin
            crit = $urandom_range(2000, 4000);
            full = crit + $urandom_range(1, 1500);
            low  = crit + $urandom_range(600);
            apply_settings($urandom_range(6), reg_val($urandom_range(3000)),
                           reg_val($urandom_range(4000, 8191)), reg_val(full),
                           reg_val(low), reg_val(crit));
        end
    endtask

    task automatic test_random_traffic(int send_pct, int stall_pct, int n_items);
        int done;
        set_idling(send_pct, stall_pct);
        done = 0;
        while (done < n_items) begin
            random_settings();
            repeat ($urandom_range(15, 40)) begin
                send_item($urandom_range(9) == 0, pick_adc());
                done++;
            end
        end
    endtask

    task automatic test_backpressure();
        apply_settings(1, RST_VALID_MIN, RST_VALID_MAX, RST_FULL, RST_LOW, RST_CRITICAL);
        set_idling(0, 0);
        rx_hold_len = 300;
        repeat (24) send_item($urandom_range(7) == 0, pick_adc());
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_defaults();
        test_poll_and_alert();
        test_interval_changes();
        test_full_below_critical();
        test_register_extremes();
        test_random_traffic(0, 0, 110);
        test_random_traffic(84, 0, 110);
        test_random_traffic(0, 84, 110);
        test_random_traffic(36, 36, 110);
        test_backpressure();
        wait_drain();
        repeat (32) @(posedge i_clk);
        $display("Sent %0d ticks and inits, checked %0d readings with %0d samples taken",
                 transfers_in, readings_out, samples_seen);
        $display("and %0d low alerts, across %0d register settings and four idling mixes.",
                 alerts_seen, settings_count);
        if (mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule

@@ files.f @@
rtl/bvm_pkg.sv
rtl/bvm_div.sv
rtl/battery_voltage_monitor.sv
tb/tb.sv
